// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// A property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// ===== hw/rtl/iptc_pkg.sv =====
// ---------------------------------------------------------------------------
// iptc_pkg
// Constants, types and prefix helpers for the IP prefix traffic counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iptc_pkg;

  localparam int NETS      = 2;
  localparam int IGNORES   = 2;
  localparam int HOST_BITS = 8;
  localparam int TBL_MAX   = 2;

  localparam int HOSTS  = 1 << HOST_BITS;
  localparam int DEPTH  = NETS * HOSTS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = 32;
  localparam int WORD_W = 2 * CNT_W;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int PFX_W     = 6;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_V4    = 4'd4;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [2:0] ST_NOT_IP      = 3'd0;
  localparam logic [2:0] ST_NOT_COUNTED = 3'd1;
  localparam logic [2:0] ST_OUTGOING    = 3'd2;
  localparam logic [2:0] ST_INCOMING    = 3'd3;
  localparam logic [2:0] ST_READ_DONE   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_NET0_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NET0_PREFIX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NET1_BASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NET1_PREFIX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IGN0_BASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IGN0_PREFIX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IGN1_BASE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IGN1_PREFIX = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic item_load;
    logic classify;
    logic addr_host;
    logic ram_write;
    logic read_capture;
    logic result_load;
    logic clear_write;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic update;
    logic read_hit;
    logic clear_last;
  } dp_stat_t;

  // A prefix is only usable when it leaves no more than HOST_BITS host bits.
  function automatic logic prefix_on(input logic [PFX_W-1:0] p);
    return (p >= PFX_W'(32 - HOST_BITS)) && (p <= PFX_W'(32)) && (p != '0);
  endfunction

  function automatic logic [31:0] prefix_mask(input logic [PFX_W-1:0] p);
    logic [PFX_W-1:0] sh;
    sh = PFX_W'(32) - p;
    if (p >= PFX_W'(32)) begin
      return 32'hFFFF_FFFF;
    end else if (p == '0) begin
      return 32'h0;
    end else begin
      return 32'hFFFF_FFFF << sh;
    end
  endfunction

  function automatic logic prefix_match(input logic [31:0] addr, input logic [31:0] base,
                                        input logic [PFX_W-1:0] p);
    return prefix_on(p) && ((addr & prefix_mask(p)) == base);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/iptc_ram.sv =====
// ---------------------------------------------------------------------------
// iptc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iptc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/iptc_dp.sv =====
// ---------------------------------------------------------------------------
// iptc_dp
// Datapath: configuration, item registers, prefix lookup and counter RAM.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iptc_dp
  import iptc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 operation,
  input  wire logic [15:0]          ether_type,
  input  wire logic [3:0]           ip_version,
  input  wire logic [31:0]          src_addr,
  input  wire logic [31:0]          dst_addr,
  input  wire logic [15:0]          ip_length,
  input  wire logic                 net_index,
  input  wire logic [7:0]           host_offset,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  output logic      [2:0]           status,
  output logic      [CNT_W-1:0]     in_bytes,
  output logic      [CNT_W-1:0]     out_bytes
);

  logic [31:0]      net_base   [TBL_MAX];
  logic [PFX_W-1:0] net_prefix [TBL_MAX];
  logic [31:0]      ign_base   [TBL_MAX];
  logic [PFX_W-1:0] ign_prefix [TBL_MAX];

  // Item registers.
  logic        op;
  logic [15:0] etype;
  logic [3:0]  ver;
  logic [31:0] src;
  logic [31:0] dst;
  logic [15:0] len;
  logic        ni;
  logic [7:0]  ho;

  // Classified item.
  logic              upd_out;
  logic [2:0]        status_q;
  logic [ADDR_W-1:0] base_idx;
  logic [ADDR_W-1:0] host_idx;
  logic [CNT_W-1:0]  rd_in;
  logic [CNT_W-1:0]  rd_out;
  logic [ADDR_W-1:0] clear_addr;

  // Lookup results.
  logic sn_hit, si_hit, dn_hit, di_hit;
  logic sn_idx, dn_idx;

  logic              ipv4;
  logic              cls_update;
  logic              cls_read_hit;
  logic              cls_upd_out;
  logic [2:0]        cls_status;
  logic [31:0]       cls_base32;
  logic [31:0]       cls_host32;
  logic              sel_net;
  logic [31:0]       sel_addr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [CNT_W-1:0]  ram_in;
  logic [CNT_W-1:0]  ram_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TBL_MAX; k++) begin
        net_base[k]   <= '0;
        net_prefix[k] <= '0;
        ign_base[k]   <= '0;
        ign_prefix[k] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NET0_BASE:   net_base[0]   <= cfg_data;
        REG_NET0_PREFIX: net_prefix[0] <= cfg_data[PFX_W-1:0];
        REG_NET1_BASE:   net_base[1]   <= cfg_data;
        REG_NET1_PREFIX: net_prefix[1] <= cfg_data[PFX_W-1:0];
        REG_IGN0_BASE:   ign_base[0]   <= cfg_data;
        REG_IGN0_PREFIX: ign_prefix[0] <= cfg_data[PFX_W-1:0];
        REG_IGN1_BASE:   ign_base[1]   <= cfg_data;
        REG_IGN1_PREFIX: ign_prefix[1] <= cfg_data[PFX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      op    <= operation;
      etype <= ether_type;
      ver   <= ip_version;
      src   <= src_addr;
      dst   <= dst_addr;
      len   <= ip_length;
      ni    <= net_index;
      ho    <= host_offset;
    end
  end

  // First hit in table order: scan downwards so the lowest match wins.
  always_comb begin
    sn_hit = 1'b0;
    sn_idx = 1'b0;
    dn_hit = 1'b0;
    dn_idx = 1'b0;
    si_hit = 1'b0;
    di_hit = 1'b0;
    for (int k = NETS - 1; k >= 0; k--) begin
      if (prefix_match(src, net_base[k], net_prefix[k])) begin
        sn_hit = 1'b1;
        sn_idx = 1'(k);
      end
      if (prefix_match(dst, net_base[k], net_prefix[k])) begin
        dn_hit = 1'b1;
        dn_idx = 1'(k);
      end
    end
    for (int k = 0; k < IGNORES; k++) begin
      if (prefix_match(src, ign_base[k], ign_prefix[k])) begin
        si_hit = 1'b1;
      end
      if (prefix_match(dst, ign_base[k], ign_prefix[k])) begin
        di_hit = 1'b1;
      end
    end
  end

  always_comb begin
    ipv4         = (etype == ETH_IPV4) && (ver == IP_V4);
    cls_update   = 1'b0;
    cls_read_hit = 1'b0;
    cls_upd_out  = 1'b0;
    cls_status   = ST_NOT_COUNTED;
    sel_net      = sn_idx;
    sel_addr     = src;
    if (op == OP_READ) begin
      cls_status   = ST_READ_DONE;
      cls_read_hit = (32'(ni) < 32'(NETS)) && (32'(ho) < 32'(HOSTS));
    end else if (!ipv4) begin
      cls_status = ST_NOT_IP;
    end else if (sn_hit && !di_hit && !dn_hit) begin
      cls_status  = ST_OUTGOING;
      cls_update  = 1'b1;
      cls_upd_out = 1'b1;
    end else if (dn_hit && !si_hit && !sn_hit) begin
      cls_status = ST_INCOMING;
      cls_update = 1'b1;
      sel_net    = dn_idx;
      sel_addr   = dst;
    end
    if (op == OP_READ) begin
      cls_base32 = (32'(ni) << HOST_BITS) + 32'(ho);
      cls_host32 = cls_base32;
    end else begin
      cls_base32 = 32'(sel_net) << HOST_BITS;
      cls_host32 = cls_base32 +
                   (sel_addr & ~prefix_mask(net_prefix[sel_net]) & 32'(HOSTS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      upd_out  <= cls_upd_out;
      status_q <= cls_status;
      base_idx <= cls_base32[ADDR_W-1:0];
      host_idx <= cls_host32[ADDR_W-1:0];
      rd_in    <= '0;
      rd_out   <= '0;
    end else if (cmd.read_capture) begin
      rd_in  <= ram_in;
      rd_out <= ram_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_write) begin
      clear_addr <= clear_addr + ADDR_W'(1);
    end
  end

  // Each word holds the incoming counter above the outgoing one.
  assign ram_in    = ram_rdata[WORD_W-1:CNT_W];
  assign ram_out   = ram_rdata[CNT_W-1:0];
  assign ram_raddr = cmd.addr_host ? host_idx : base_idx;
  assign ram_we    = cmd.ram_write || cmd.clear_write;

  always_comb begin
    ram_waddr = cmd.clear_write ? clear_addr : ram_raddr;
    if (cmd.clear_write || (op == OP_READ)) begin
      ram_wdata = '0;
    end else if (upd_out) begin
      ram_wdata = {ram_in, ram_out + CNT_W'(len)};
    end else begin
      ram_wdata = {ram_in + CNT_W'(len), ram_out};
    end
  end

  iptc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      status    <= status_q;
      in_bytes  <= rd_in;
      out_bytes <= rd_out;
    end
  end

  // The classification is worked out from the held item, which stays put
  // until the next beat is taken, so the controller can branch on it at once.
  assign stat.update     = cls_update;
  assign stat.read_hit   = cls_read_hit;
  assign stat.clear_last = (clear_addr == ADDR_W'(DEPTH - 1));

endmodule

`default_nettype wire

// ===== hw/rtl/iptc_ctrl.sv =====
// ---------------------------------------------------------------------------
// iptc_ctrl
// Sequencer for clearing, classification and counter read-modify-write.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module iptc_ctrl
  import iptc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_CLASS   = 8'b0000_0100,
    S_RD_BASE = 8'b0000_1000,
    S_WR_BASE = 8'b0001_0000,
    S_RD_HOST = 8'b0010_0000,
    S_WR_HOST = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_next    = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        state_next   = (stat.update || stat.read_hit) ? S_RD_BASE : S_DONE;
      end
      S_RD_BASE: begin
        state_next = S_WR_BASE;
      end
      S_WR_BASE: begin
        cmd.ram_write    = 1'b1;
        cmd.read_capture = stat.read_hit;
        state_next       = stat.update ? S_RD_HOST : S_DONE;
      end
      S_RD_HOST: begin
        cmd.addr_host = 1'b1;
        state_next    = S_WR_HOST;
      end
      S_WR_HOST: begin
        cmd.addr_host = 1'b1;
        cmd.ram_write = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_CLK(a_accept_to_class, clk, rst, (in_valid && !in_stall) |=> (state == S_CLASS), "accepted beat did not start classification")
  `ASSERT_CLK(a_load_shows, clk, rst, cmd.result_load |=> out_valid, "loaded result not presented")
  `ASSERT_NEVER(a_no_overwrite, clk, rst, cmd.result_load && out_valid && out_stall, "result overwritten while stalled")

endmodule

`default_nettype wire

// ===== hw/rtl/ip_prefix_traffic_counter_top.sv =====
// ---------------------------------------------------------------------------
// ip_prefix_traffic_counter_top
// Per-host IPv4 byte accounting for internal networks.
// ---------------------------------------------------------------------------
// The input channel carries one beat per parsed packet header, or one
// read-and-clear request when operation is high. A beat is taken at a rising
// edge where in_valid is high and in_stall is low; the output channel works
// the same way with out_valid and out_stall and gives one result beat for
// every input beat, in order.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data) and is
// only to be written while the block is idle.
// After a beat is taken it is classified; a frame that is not IPv4 or is not
// counted then goes straight to its result, a read-and-clear reads and clears
// its counter word in a single read-modify-write pass, and a counted packet does
// two passes through the counter RAM (network total, then host). That
// read-modify-write sequence sets the pace: one item is worked on at a time,
// and a new beat is taken only once the previous result sits in the output
// register.
// After reset the counter RAM is cleared one word per cycle, all 512 words
// (NETS * 2^HOST_BITS), during which in_stall stays high.
// While the receiver stalls, the held result stays stable and the block
// finishes the next item up to its result, then waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ip_prefix_traffic_counter_top
  import iptc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration write port.
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // Input channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 operation,
  input  wire logic [15:0]          ether_type,
  input  wire logic [3:0]           ip_version,
  input  wire logic [31:0]          src_addr,
  input  wire logic [31:0]          dst_addr,
  input  wire logic [15:0]          ip_length,
  input  wire logic                 net_index,
  input  wire logic [7:0]           host_offset,
  // Output channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [2:0]           status,
  output logic      [CNT_W-1:0]     in_bytes,
  output logic      [CNT_W-1:0]     out_bytes
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller owns the handshakes; the datapath owns every payload bit.
  iptc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  iptc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .operation   (operation),
    .ether_type  (ether_type),
    .ip_version  (ip_version),
    .src_addr    (src_addr),
    .dst_addr    (dst_addr),
    .ip_length   (ip_length),
    .net_index   (net_index),
    .host_offset (host_offset),
    .cmd         (cmd),
    .stat        (stat),
    .status      (status),
    .in_bytes    (in_bytes),
    .out_bytes   (out_bytes)
  );

endmodule

`default_nettype wire
